>>> hw/rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, select codes and controller/datapath interface types
// for the RC4 stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    localparam int KEY_BYTES  = 16;
    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int KPOS_W     = $clog2(KEY_BYTES);
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_W      = 2 * CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN = 2'd2;

    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 5'd1;

    typedef enum logic [2:0] {
        RD_K,
        RD_ACC,
        RD_I,
        RD_J,
        RD_T
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_K,
        WR_ACC,
        WR_I,
        WR_J
    } wr_sel_t;

    typedef struct packed {
        logic    in_ready;
        logic    ks_init;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    acc_step;
        logic    k_step;
        logic    i_step;
        logic    j_step;
        logic    t_step;
        logic    ks_step;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic k_last;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, read-first on an address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for the RC4 block: key schedule swap loop and per-byte
// generator step, driving the datapath through a command struct.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ctrl
    import rc4_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    input  wire logic    s_start_of_message,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_K_RD = 4'd1;
    localparam logic [3:0] ST_K_AC = 4'd2;
    localparam logic [3:0] ST_K_WA = 4'd3;
    localparam logic [3:0] ST_K_WB = 4'd4;
    localparam logic [3:0] ST_G_RD = 4'd5;
    localparam logic [3:0] ST_G_J  = 4'd6;
    localparam logic [3:0] ST_G_T  = 4'd7;
    localparam logic [3:0] ST_G_KS = 4'd8;
    localparam logic [3:0] ST_G_OU = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = RD_K;
        cmd.wr_sel = WR_K;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_valid) begin
                    if (s_start_of_message) begin
                        cmd.ks_init = 1'b1;
                        state_next  = ST_K_RD;
                    end else begin
                        state_next = ST_G_RD;
                    end
                end
            end
            ST_K_RD: begin
                cmd.rd_sel = RD_K;
                state_next = ST_K_AC;
            end
            ST_K_AC: begin
                cmd.rd_sel   = RD_ACC;
                cmd.acc_step = 1'b1;
                state_next   = ST_K_WA;
            end
            ST_K_WA: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_K;
                state_next = ST_K_WB;
            end
            ST_K_WB: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_ACC;
                cmd.k_step = 1'b1;
                state_next = sts.k_last ? ST_G_RD : ST_K_RD;
            end
            ST_G_RD: begin
                cmd.rd_sel = RD_I;
                cmd.i_step = 1'b1;
                state_next = ST_G_J;
            end
            ST_G_J: begin
                cmd.rd_sel = RD_J;
                cmd.j_step = 1'b1;
                state_next = ST_G_T;
            end
            ST_G_T: begin
                cmd.rd_sel = RD_T;
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_I;
                cmd.t_step = 1'b1;
                state_next = ST_G_KS;
            end
            ST_G_KS: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_J;
                cmd.ks_step = 1'b1;
                state_next  = ST_G_OU;
            end
            ST_G_OU: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ks_to_gen: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_K_WB && sts.k_last) |=> (state_reg == ST_G_RD))
        else $error("key schedule did not hand over to generator step");

    a_som_starts_ks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid && s_start_of_message) |=> (state_reg == ST_K_RD))
        else $error("start of message did not start key schedule");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten while full");

endmodule

`default_nettype wire

>>> hw/rtl/rc4_dp.sv
// ----------------------------------------------------------------------------
// rc4_dp
// RC4 datapath: key registers, permutation RAM with per-entry valid bits
// (invalid entry reads as its own index), generator indices, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp
    import rc4_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_sts_t                    sts,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [BYTE_W-1:0]     m_cipher_byte
);

    localparam int ADDR_W = $clog2(PERM_DEPTH);

    logic [CFG_DATA_W-1:0] key_lo_reg;
    logic [CFG_DATA_W-1:0] key_hi_reg;
    logic [LEN_W-1:0]      key_len_reg;

    logic [BYTE_W-1:0]     data_reg;
    logic [PERM_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]     rd_addr_q_reg;
    logic                  rd_valid_q_reg;

    logic [ADDR_W-1:0]     k_reg;
    logic [ADDR_W-1:0]     acc_reg;
    logic [KPOS_W-1:0]     kpos_reg;
    logic [BYTE_W-1:0]     sk_reg;

    logic [ADDR_W-1:0]     i_reg;
    logic [ADDR_W-1:0]     j_reg;
    logic [BYTE_W-1:0]     si_reg;
    logic [BYTE_W-1:0]     sj_reg;
    logic [ADDR_W-1:0]     t_reg;
    logic [BYTE_W-1:0]     cipher_reg;

    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     m_cipher_reg;

    logic [BYTE_W-1:0]     ram_rd_data;
    logic [BYTE_W-1:0]     s_val;
    logic [KEY_W-1:0]      key_all;
    logic [BYTE_W-1:0]     key_byte;
    logic [LEN_W-1:0]      used_len;
    logic [LEN_W-1:0]      len_m1;
    logic [ADDR_W-1:0]     acc_sum;
    logic [ADDR_W-1:0]     i_inc;
    logic [ADDR_W-1:0]     j_sum;
    logic [ADDR_W-1:0]     t_sum;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [BYTE_W-1:0]     wr_data;
    logic [BYTE_W-1:0]     ks;

    // Unused entries read back as their index (identity permutation)
    assign s_val    = rd_valid_q_reg ? ram_rd_data : rd_addr_q_reg;
    assign key_all  = {key_hi_reg, key_lo_reg};
    assign key_byte = key_all[kpos_reg*BYTE_W +: BYTE_W];

    always_comb begin
        used_len = key_len_reg;
        if (key_len_reg == '0) begin
            used_len = LEN_W'(1);
        end else if (key_len_reg > LEN_W'(KEY_BYTES)) begin
            used_len = LEN_W'(KEY_BYTES);
        end
    end

    assign len_m1  = used_len - LEN_W'(1);
    assign acc_sum = ADDR_W'(acc_reg + s_val + key_byte);
    assign i_inc   = i_reg + ADDR_W'(1);
    assign j_sum   = ADDR_W'(j_reg + s_val);
    assign t_sum   = ADDR_W'(si_reg + s_val);

    always_comb begin
        unique case (cmd.rd_sel)
            RD_K:    rd_addr = k_reg;
            RD_ACC:  rd_addr = acc_sum;
            RD_I:    rd_addr = i_inc;
            RD_J:    rd_addr = j_sum;
            RD_T:    rd_addr = t_sum;
            default: rd_addr = k_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.wr_sel)
            WR_K: begin
                wr_addr = k_reg;
                wr_data = s_val;
            end
            WR_ACC: begin
                wr_addr = acc_reg;
                wr_data = sk_reg;
            end
            WR_I: begin
                wr_addr = i_reg;
                wr_data = s_val;
            end
            WR_J: begin
                wr_addr = j_reg;
                wr_data = si_reg;
            end
            default: begin
                wr_addr = k_reg;
                wr_data = s_val;
            end
        endcase
    end

    // S[t] after the swap: S[j] now holds old S[i], S[i] holds old S[j]
    always_comb begin
        priority if (t_reg == j_reg) begin
            ks = si_reg;
        end else if (t_reg == i_reg) begin
            ks = sj_reg;
        end else begin
            ks = s_val;
        end
    end

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
            key_len_reg <= KEY_LEN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_LO:  key_lo_reg  <= cfg_data;
                CFG_KEY_HI:  key_hi_reg  <= cfg_data;
                CFG_KEY_LEN: key_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.ks_init) begin
                valid_reg <= '0;
                i_reg     <= '0;
                j_reg     <= '0;
            end else begin
                if (cmd.wr_en) begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (cmd.i_step) begin
                    i_reg <= i_inc;
                end
                if (cmd.j_step) begin
                    j_reg <= j_sum;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_q_reg  <= rd_addr;
        rd_valid_q_reg <= valid_reg[rd_addr];
        if (cmd.in_ready && s_valid) begin
            data_reg <= s_data_byte;
        end
        if (cmd.ks_init) begin
            k_reg    <= '0;
            acc_reg  <= '0;
            kpos_reg <= '0;
        end
        if (cmd.acc_step) begin
            sk_reg  <= s_val;
            acc_reg <= acc_sum;
        end
        if (cmd.k_step) begin
            k_reg    <= k_reg + ADDR_W'(1);
            kpos_reg <= (kpos_reg == len_m1[KPOS_W-1:0]) ? '0 : kpos_reg + KPOS_W'(1);
        end
        if (cmd.j_step) begin
            si_reg <= s_val;
        end
        if (cmd.t_step) begin
            sj_reg <= s_val;
            t_reg  <= t_sum;
        end
        if (cmd.ks_step) begin
            cipher_reg <= data_reg ^ ks;
        end
        if (cmd.out_load) begin
            m_cipher_reg <= cipher_reg;
        end
    end

    assign sts.k_last   = (k_reg == {ADDR_W{1'b1}});
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_cipher_byte = m_cipher_reg;

    a_out_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented after load");

    a_ks_clears_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ks_init |=> (valid_reg == '0))
        else $error("permutation not reset to identity at key schedule");

endmodule

`default_nettype wire

>>> hw/rtl/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher: key schedule on start of message, one generator step
// and XOR per byte. Controller and datapath around one permutation RAM.
// ----------------------------------------------------------------------------
// Per request: read/swap sequence on the single-write-port permutation RAM,
//   then output load once the output register is free; one request at a time.
// Start of message adds the key schedule before the generator step: 256 swaps.
// Reset: synchronous, active low; keys cleared, key length 1, permutation
//   identity via per-entry valid bits (no clearing pass), indices zero.
`default_nettype none

module rc4_stream_cipher
    import rc4_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [BYTE_W-1:0]     s_data_byte,
    input  wire logic                  s_start_of_message,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [BYTE_W-1:0]     m_cipher_byte
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;
    assign s_ready   = cmd.in_ready;

    rc4_ctrl u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_start_of_message (s_start_of_message),
        .sts                (sts),
        .cmd                (cmd)
    );

    rc4_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cipher_byte (m_cipher_byte)
    );

endmodule

`default_nettype wire
